// ===== design/hpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the Horner polynomial evaluator.
// No dependencies.
package hpe_pkg;

  localparam int DEG_W     = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEFF0 = CFG_IDX_W'(1);

endpackage

// ===== design/hpe_intf.sv =====
`timescale 1ns / 1ps
// Channel interfaces: sample input, result output and register write port.
// Depends on hpe_pkg.
interface hpe_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_x;

  modport source (output valid, output sample_x, input ready);
  modport sink   (input valid, input sample_x, output ready);
endinterface

interface hpe_out_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] poly_value;
  logic                         overflow;

  modport source (output valid, output poly_value, output overflow, input ready);
  modport sink   (input valid, input poly_value, input overflow, output ready);
endinterface

interface hpe_cfg_if #(parameter int DATA_WIDTH = 32);
  import hpe_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [DATA_WIDTH-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== design/hpe_cell.sv =====
`timescale 1ns / 1ps
// One Horner step: multiply by x, floor-shift, saturate, add coefficient, saturate.
// Two register stages with per-stage handshake. Depends on hpe_pkg.
module hpe_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int COEFF_IDX  = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [hpe_pkg::DEG_W-1:0]    degree,
  input  logic signed [DATA_WIDTH-1:0] coeff,
  input  logic                         up_vld,
  output logic                         up_rdy,
  input  logic signed [DATA_WIDTH-1:0] up_x,
  input  logic signed [DATA_WIDTH-1:0] up_acc,
  input  logic                         up_ovf,
  output logic                         dn_vld,
  input  logic                         dn_rdy,
  output logic signed [DATA_WIDTH-1:0] dn_x,
  output logic signed [DATA_WIDTH-1:0] dn_acc,
  output logic                         dn_ovf
);
  import hpe_pkg::*;

  localparam int PW = 2 * DATA_WIDTH;
  localparam logic [DEG_W-1:0] IDX = DEG_W'(COEFF_IDX);
  localparam logic signed [DATA_WIDTH-1:0] POS_LIM = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] NEG_LIM = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                         s1_vld_r, s1_vld_nxt;
  logic signed [PW-1:0]         s1_prod_r;
  logic signed [DATA_WIDTH-1:0] s1_x_r;
  logic                         s1_ovf_r;
  logic                         s2_vld_r, s2_vld_nxt;
  logic signed [DATA_WIDTH-1:0] s2_acc_r, s2_acc_nxt;
  logic signed [DATA_WIDTH-1:0] s2_x_r;
  logic                         s2_ovf_r, s2_ovf_nxt;

  logic                         s1_take, s2_take;
  logic signed [PW-1:0]         prod, shifted;
  logic                         mul_ok, add_ok, active;
  logic signed [DATA_WIDTH-1:0] mul_sat, add_sat;
  logic        [DATA_WIDTH:0]   sum;

  assign s2_take = !s2_vld_r || dn_rdy;
  assign s1_take = !s1_vld_r || s2_take;
  assign up_rdy  = s1_take;

  assign prod = PW'(up_acc) * PW'(up_x);

  // floor shift, then clamp product and sum to the word range
  always_comb begin
    shifted = s1_prod_r >>> FRAC_BITS;
    mul_ok  = (&shifted[PW-1:DATA_WIDTH-1]) || !(|shifted[PW-1:DATA_WIDTH-1]);
    mul_sat = mul_ok ? shifted[DATA_WIDTH-1:0] : (shifted[PW-1] ? NEG_LIM : POS_LIM);
    sum     = {mul_sat[DATA_WIDTH-1], mul_sat} + {coeff[DATA_WIDTH-1], coeff};
    add_ok  = sum[DATA_WIDTH] == sum[DATA_WIDTH-1];
    add_sat = add_ok ? sum[DATA_WIDTH-1:0] : (sum[DATA_WIDTH] ? NEG_LIM : POS_LIM);
    active  = IDX < degree;
    s1_vld_nxt = s1_take ? up_vld : s1_vld_r;
    s2_vld_nxt = s2_take ? s1_vld_r : s2_vld_r;
    s2_acc_nxt = active ? add_sat : coeff;
    s2_ovf_nxt = s1_ovf_r | (active & (!mul_ok | !add_ok));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && up_vld) begin
      s1_prod_r <= prod;
      s1_x_r    <= up_x;
      s1_ovf_r  <= up_ovf;
    end
    if (s2_take && s1_vld_r) begin
      s2_acc_r <= s2_acc_nxt;
      s2_x_r   <= s1_x_r;
      s2_ovf_r <= s2_ovf_nxt;
    end
  end

  assign dn_vld = s2_vld_r;
  assign dn_x   = s2_x_r;
  assign dn_acc = s2_acc_r;
  assign dn_ovf = s2_ovf_r;

endmodule

// ===== design/horner_polynomial_evaluator_core.sv =====
`timescale 1ns / 1ps
// Horner polynomial evaluator, signed fixed point with FRAC_BITS fraction bits.
// Accepts one sample x per cycle and returns one saturated value per sample,
// plus an overflow flag set if any multiply or add step clipped. The sample
// passes a chain of MAX_DEGREE multiply-add cells, each two register stages
// deep, then an output register, whatever the programmed degree. Stalls
// propagate back stage by stage, so bubbles are squeezed out. Degree and
// coefficients are written through the cfg channel (index 0 degree,
// 1..MAX_DEGREE+1 coefficients); the user must write them only while no
// sample is in flight, as the block does not enforce this. Degrees above
// MAX_DEGREE act as MAX_DEGREE. Depends on hpe_pkg, hpe_intf and hpe_cell.
module horner_polynomial_evaluator_core #(
  parameter int MAX_DEGREE = 6,
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hpe_in_if.sink      in_ch,
  hpe_out_if.source   out_ch,
  hpe_cfg_if.sink     cfg_ch
);
  import hpe_pkg::*;

  localparam logic [DEG_W-1:0] MAX_DEG_L = DEG_W'(MAX_DEGREE);

  logic [DEG_W-1:0]             degree_r;
  logic signed [DATA_WIDTH-1:0] coeff_r [MAX_DEGREE+1];
  logic [DEG_W-1:0]             deg_eff;

  logic                         lk_vld [MAX_DEGREE+1];
  logic                         lk_rdy [MAX_DEGREE+1];
  logic signed [DATA_WIDTH-1:0] lk_x   [MAX_DEGREE+1];
  logic signed [DATA_WIDTH-1:0] lk_acc [MAX_DEGREE+1];
  logic                         lk_ovf [MAX_DEGREE+1];

  logic                         out_vld_r;
  logic signed [DATA_WIDTH-1:0] poly_r;
  logic                         ovf_r;
  logic                         cfg_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
      for (int j = 0; j <= MAX_DEGREE; j++) coeff_r[j] <= '0;
    end else if (cfg_wr) begin
      if (cfg_ch.index == REG_DEGREE) degree_r <= cfg_ch.wdata[DEG_W-1:0];
      for (int j = 0; j <= MAX_DEGREE; j++) begin
        if (cfg_ch.index == REG_COEFF0 + CFG_IDX_W'(j)) coeff_r[j] <= cfg_ch.wdata;
      end
    end
  end

  assign deg_eff = (degree_r > MAX_DEG_L) ? MAX_DEG_L : degree_r;

  assign lk_vld[0]   = in_ch.valid;
  assign lk_x[0]     = in_ch.sample_x;
  assign lk_acc[0]   = coeff_r[MAX_DEGREE];
  assign lk_ovf[0]   = 1'b0;
  assign in_ch.ready = lk_rdy[0];

  for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_cell
    hpe_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .COEFF_IDX  (MAX_DEGREE - 1 - k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .degree (deg_eff),
      .coeff  (coeff_r[MAX_DEGREE-1-k]),
      .up_vld (lk_vld[k]),
      .up_rdy (lk_rdy[k]),
      .up_x   (lk_x[k]),
      .up_acc (lk_acc[k]),
      .up_ovf (lk_ovf[k]),
      .dn_vld (lk_vld[k+1]),
      .dn_rdy (lk_rdy[k+1]),
      .dn_x   (lk_x[k+1]),
      .dn_acc (lk_acc[k+1]),
      .dn_ovf (lk_ovf[k+1])
    );
  end

  assign lk_rdy[MAX_DEGREE] = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (lk_rdy[MAX_DEGREE]) begin
      out_vld_r <= lk_vld[MAX_DEGREE];
    end
  end

  always_ff @(posedge clk) begin
    if (lk_rdy[MAX_DEGREE] && lk_vld[MAX_DEGREE]) begin
      poly_r <= lk_acc[MAX_DEGREE];
      ovf_r  <= lk_ovf[MAX_DEGREE];
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.poly_value = poly_r;
  assign out_ch.overflow   = ovf_r;

  // input back-pressure only ever comes from a stalled output word
  a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_vld_r && !out_ch.ready))
    else $error("input stalled without output stall");

  // pipeline is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_ch.valid)
    else $error("output word present after reset");

endmodule
